// ----- hw/rtl/rle_pkg.sv -----
package rle_pkg;

  // Longest run written as one length/byte pair.
  localparam logic [7:0] MaxRun = 8'd128;

  // Literal stretch storage.
  localparam int unsigned LitDepth = 128;
  localparam int unsigned LitAw = $clog2(LitDepth);
  localparam logic [7:0] LitMax = 8'(LitDepth);

  localparam logic [7:0] TermByte = 8'd128;
  localparam logic [8:0] RunBase = 9'd257;

  // One encoded byte handed from the sequencer to the chunk packer.
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
  } emit_t;

endpackage

// ----- hw/rtl/rle_if.sv -----
interface rle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       end_of_data;

  modport source (output valid, output data_byte, output byte_present, output end_of_data,
                  input ready);
  modport sink (input valid, input data_byte, input byte_present, input end_of_data,
                output ready);
endinterface

interface rle_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] out_chunk;
  logic [3:0]  chunk_bytes;
  logic        stream_done;

  modport source (output valid, output out_chunk, output chunk_bytes, output stream_done,
                  input ready);
  modport sink (input valid, input out_chunk, input chunk_bytes, input stream_done,
                output ready);
endinterface

// ----- hw/rtl/rle_ram.sv -----
module rle_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/rle_pack.sv -----
module rle_pack
  import rle_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  emit_t            emit_i,
  output logic             emit_ready_o,
  rle_out_if.source        out_o
);

  logic [63:0] pack_q, pack_d;
  logic [2:0]  fill_q, fill_d;
  logic        out_valid_q, out_valid_d;
  logic [63:0] chunk_q, chunk_d;
  logic [3:0]  count_q, count_d;
  logic        done_q, done_d;

  logic [63:0] merged;
  logic        completes;
  logic        slot_free;
  logic        take;

  // Slot s of the chunk sits at bits 63-8s down to 56-8s.
  assign merged    = pack_q | (64'(emit_i.data) << {3'(~fill_q), 3'b000});
  assign completes = (fill_q == 3'd7) || emit_i.last;
  assign slot_free = !out_valid_q || out_o.ready;
  assign emit_ready_o = !completes || slot_free;
  assign take      = emit_i.valid && emit_ready_o;

  always_comb begin
    pack_d      = pack_q;
    fill_d      = fill_q;
    out_valid_d = out_valid_q && !out_o.ready;
    chunk_d     = chunk_q;
    count_d     = count_q;
    done_d      = done_q;
    if (take) begin
      if (completes) begin
        out_valid_d = 1'b1;
        chunk_d     = merged;
        count_d     = 4'(fill_q) + 4'd1;
        done_d      = emit_i.last;
        pack_d      = '0;
        fill_d      = '0;
      end else begin
        pack_d = merged;
        fill_d = fill_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pack_q      <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pack_q      <= pack_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chunk_q <= chunk_d;
    count_q <= count_d;
    done_q  <= done_d;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.out_chunk   = chunk_q;
  assign out_o.chunk_bytes = count_q;
  assign out_o.stream_done = done_q;

endmodule

// ----- hw/rtl/run_length_byte_encoder.sv -----
// Channel  Dir  Payload                                  Role
// in_i     in   data_byte, byte_present, end_of_data     raw bytes and end mark
// out_o    out  out_chunk, chunk_bytes, stream_done      encoded 8-byte chunks
//
// An item is taken in ST_IDLE; the sequencer then makes one decision per cycle in ST_SETTLE
// (window shift, run growth or literal store write) and emits each encoded byte in turn.
// A literal flush reads the stretch back from the literal RAM one entry per cycle while
// the packer takes bytes; it stalls when a completed chunk finds the output register full.
// No clearing pass after reset: the literal RAM is only read where written.
// A full output register stalls the sequencer only when a chunk completes.
module run_length_byte_encoder
  import rle_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  rle_in_if.sink in_i,
  rle_out_if.source out_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETTLE,
    ST_REP_LEN,
    ST_REP_BYTE,
    ST_LIT_LEN,
    ST_LIT_DATA,
    ST_TERM
  } state_e;

  state_e           state_q, state_d;
  logic [7:0]       win_q [3];
  logic [7:0]       win_d [3];
  logic [1:0]       wfill_q, wfill_d;
  logic [7:0]       lit_count_q, lit_count_d;
  logic [7:0]       rep_byte_q, rep_byte_d;
  logic [7:0]       rep_count_q, rep_count_d;
  logic             end_q, end_d;
  logic [LitAw-1:0] idx_q, idx_d;

  emit_t            emit;
  logic             emit_ready;
  logic             ram_we;
  logic [7:0]       ram_rdata;
  logic             in_take;
  state_e           settled;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_take    = in_i.valid && in_i.ready;
  assign settled    = end_q ? ST_TERM : ST_IDLE;

  always_comb begin
    state_d     = state_q;
    win_d       = win_q;
    wfill_d     = wfill_q;
    lit_count_d = lit_count_q;
    rep_byte_d  = rep_byte_q;
    rep_count_d = rep_count_q;
    end_d       = end_q;
    idx_d       = idx_q;
    ram_we      = 1'b0;
    emit        = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_take) begin
          end_d   = in_i.end_of_data;
          state_d = ST_SETTLE;
          if (in_i.byte_present && wfill_q != 2'd3) begin
            case (wfill_q)
              2'd0:    win_d[0] = in_i.data_byte;
              2'd1:    win_d[1] = in_i.data_byte;
              default: win_d[2] = in_i.data_byte;
            endcase
            wfill_d = wfill_q + 2'd1;
          end
        end
      end

      ST_SETTLE: begin
        if (rep_count_q != 8'd0) begin
          if (rep_count_q >= MaxRun) begin
            state_d = ST_REP_LEN;
          end else if (wfill_q == 2'd0) begin
            state_d = end_q ? ST_REP_LEN : ST_IDLE;
          end else if (win_q[0] == rep_byte_q) begin
            win_d[0]    = win_q[1];
            win_d[1]    = win_q[2];
            win_d[2]    = '0;
            wfill_d     = wfill_q - 2'd1;
            rep_count_d = rep_count_q + 8'd1;
          end else begin
            state_d = ST_REP_LEN;
          end
        end else if (lit_count_q != 8'd0) begin
          if (wfill_q == 2'd0) begin
            if (end_q) begin
              state_d = ST_LIT_LEN;
              idx_d   = '0;
            end else begin
              state_d = ST_IDLE;
            end
          end else if (lit_count_q >= LitMax ||
                       (wfill_q == 2'd3 && win_q[0] == win_q[1] && win_q[0] == win_q[2])) begin
            state_d = ST_LIT_LEN;
            idx_d   = '0;
          end else if (wfill_q != 2'd3 && !end_q) begin
            state_d = ST_IDLE;
          end else begin
            ram_we      = 1'b1;
            win_d[0]    = win_q[1];
            win_d[1]    = win_q[2];
            win_d[2]    = '0;
            wfill_d     = wfill_q - 2'd1;
            lit_count_d = lit_count_q + 8'd1;
          end
        end else begin
          if (wfill_q == 2'd0 || (wfill_q == 2'd1 && !end_q)) begin
            state_d = settled;
          end else if (wfill_q != 2'd1 && win_q[0] == win_q[1]) begin
            rep_byte_d  = win_q[0];
            rep_count_d = 8'd2;
            win_d[0]    = win_q[2];
            win_d[1]    = '0;
            win_d[2]    = '0;
            wfill_d     = wfill_q - 2'd2;
          end else begin
            // The write address is lit_count, which is zero here.
            ram_we      = 1'b1;
            win_d[0]    = win_q[1];
            win_d[1]    = win_q[2];
            win_d[2]    = '0;
            wfill_d     = wfill_q - 2'd1;
            lit_count_d = 8'd1;
          end
        end
        // A stream end with nothing left to settle goes on to the terminator.
        if (state_d == ST_IDLE) begin
          state_d = settled;
        end
      end

      ST_REP_LEN: begin
        emit.valid = 1'b1;
        emit.data  = 8'(RunBase - 9'(rep_count_q));
        if (emit_ready) begin
          state_d = ST_REP_BYTE;
        end
      end

      ST_REP_BYTE: begin
        emit.valid = 1'b1;
        emit.data  = rep_byte_q;
        if (emit_ready) begin
          rep_count_d = '0;
          state_d     = ST_SETTLE;
        end
      end

      ST_LIT_LEN: begin
        emit.valid = 1'b1;
        emit.data  = lit_count_q - 8'd1;
        if (emit_ready) begin
          state_d = ST_LIT_DATA;
        end
      end

      ST_LIT_DATA: begin
        // The RAM reads at idx_d, so the data here belongs to idx_q.
        emit.valid = 1'b1;
        emit.data  = ram_rdata;
        if (emit_ready) begin
          if ({1'b0, idx_q} == lit_count_q - 8'd1) begin
            lit_count_d = '0;
            state_d     = ST_SETTLE;
          end else begin
            idx_d = idx_q + LitAw'(1);
          end
        end
      end

      ST_TERM: begin
        emit.valid = 1'b1;
        emit.data  = TermByte;
        emit.last  = 1'b1;
        if (emit_ready) begin
          lit_count_d = '0;
          rep_count_d = '0;
          rep_byte_d  = '0;
          wfill_d     = '0;
          win_d[0]    = '0;
          win_d[1]    = '0;
          win_d[2]    = '0;
          end_d       = 1'b0;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      win_q[0]    <= '0;
      win_q[1]    <= '0;
      win_q[2]    <= '0;
      wfill_q     <= '0;
      lit_count_q <= '0;
      rep_byte_q  <= '0;
      rep_count_q <= '0;
      end_q       <= 1'b0;
      idx_q       <= '0;
    end else begin
      state_q     <= state_d;
      win_q       <= win_d;
      wfill_q     <= wfill_d;
      lit_count_q <= lit_count_d;
      rep_byte_q  <= rep_byte_d;
      rep_count_q <= rep_count_d;
      end_q       <= end_d;
      idx_q       <= idx_d;
    end
  end

  rle_ram #(
    .Width(8),
    .Depth(LitDepth)
  ) u_lit_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (lit_count_q[LitAw-1:0]),
    .wdata_i (win_q[0]),
    .raddr_i (idx_d),
    .rdata_o (ram_rdata)
  );

  rle_pack u_pack (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .emit_i       (emit),
    .emit_ready_o (emit_ready),
    .out_o        (out_o)
  );

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import rle_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned IdlePct = 25;
  localparam int unsigned DrainCycles = 300;
  localparam int unsigned MaxPrinted = 50;

  typedef struct {
    logic [63:0] chunk;
    logic [3:0]  nbytes;
    logic        done;
  } chunk_t;

  logic clk;
  logic rst_n;

  rle_in_if  in_if ();
  rle_out_if out_if ();

  run_length_byte_encoder u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Encoder state mirrored by the testbench.
  logic [7:0]  lit_mem [LitDepth];
  int unsigned lit_cnt;
  logic [7:0]  run_byte;
  int unsigned run_cnt;
  logic [7:0]  win [3];
  int unsigned win_fill;
  logic [63:0] pack_buf;
  int unsigned pack_fill;

  chunk_t      expected_chunks_q [$];
  int unsigned err_count;
  int unsigned cycle_count;
  bit          src_idle_en;
  bit          snk_idle_en;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    if (err_count < MaxPrinted) $display("mismatch at cycle %0d: %s", cycle_count, msg);
    err_count++;
  endtask

  function automatic void reset_encoder_state();
    foreach (lit_mem[i]) lit_mem[i] = 8'h00;
    lit_cnt = 0;
    run_byte = 8'h00;
    run_cnt = 0;
    win = '{default: 8'h00};
    win_fill = 0;
    pack_buf = '0;
    pack_fill = 0;
  endfunction

  function automatic void pack_byte(input logic [7:0] b, input bit last);
    int unsigned slot;
    chunk_t c;
    slot = pack_fill % 8;
    pack_buf |= 64'(b) << (56 - 8 * slot);
    pack_fill = slot + 1;
    if (pack_fill == 8 || last) begin
      c.chunk = pack_buf;
      c.nbytes = 4'(pack_fill);
      c.done = last;
      expected_chunks_q.push_back(c);
      pack_buf = '0;
      pack_fill = 0;
    end
  endfunction

  function automatic logic [7:0] take_window();
    logic [7:0] b;
    b = win[0];
    win[0] = win[1];
    win[1] = win[2];
    win[2] = 8'h00;
    if (win_fill > 0) win_fill--;
    return b;
  endfunction

  function automatic void write_run();
    pack_byte(8'(RunBase - 9'(run_cnt)), 1'b0);
    pack_byte(run_byte, 1'b0);
    run_cnt = 0;
  endfunction

  function automatic void write_literal();
    pack_byte(8'(lit_cnt - 1), 1'b0);
    for (int unsigned k = 0; k < lit_cnt; k++) pack_byte(lit_mem[LitAw'(k)], 1'b0);
    lit_cnt = 0;
  endfunction

  // Assigns window bytes to runs and literal stretches until more input is needed.
  function automatic void resolve_window(input bit eod);
    while (1) begin
      if (run_cnt != 0) begin
        if (run_cnt >= MaxRun) write_run();
        else if (win_fill == 0) begin
          if (eod) write_run();
          else break;
        end else if (win[0] == run_byte) begin
          void'(take_window());
          run_cnt++;
        end else write_run();
      end else if (lit_cnt != 0) begin
        if (win_fill == 0) begin
          if (eod) write_literal();
          else break;
        end else if (lit_cnt >= LitDepth) write_literal();
        else if (win_fill >= 3 && win[0] == win[1] && win[0] == win[2]) write_literal();
        else if (win_fill < 3 && !eod) break;
        else begin
          lit_mem[LitAw'(lit_cnt)] = take_window();
          lit_cnt++;
        end
      end else begin
        if (win_fill == 0) break;
        if (win_fill == 1 && !eod) break;
        if (win_fill >= 2 && win[0] == win[1]) begin
          run_byte = take_window();
          void'(take_window());
          run_cnt = 2;
        end else begin
          lit_mem[0] = take_window();
          lit_cnt = 1;
        end
      end
    end
  endfunction

  function automatic void encode_item(input logic [7:0] d, input bit p, input bit eod);
    if (p && win_fill < 3) begin
      win[2'(win_fill)] = d;
      win_fill++;
    end
    resolve_window(eod);
    if (eod) begin
      pack_byte(TermByte, 1'b1);
      lit_cnt = 0;
      run_cnt = 0;
      run_byte = 8'h00;
      win_fill = 0;
      win = '{default: 8'h00};
    end
  endfunction

  // Offers one item and updates the expected chunks once the transaction completes.
  task automatic send_item(input logic [7:0] d, input bit p, input bit eod);
    while (src_idle_en && $urandom_range(0, 99) < IdlePct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data_byte <= d;
    in_if.byte_present <= p;
    in_if.end_of_data <= eod;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    encode_item(d, p, eod);
  endtask

  task automatic send_byte(input logic [7:0] d);
    send_item(d, 1'b1, 1'b0);
  endtask

  task automatic send_end_mark(input bit with_byte, input logic [7:0] d);
    send_item(with_byte ? d : 8'($urandom), with_byte, 1'b1);
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (expected_chunks_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      out_if.ready <= !(snk_idle_en && $urandom_range(0, 99) < IdlePct);
    end
  end

  initial begin
    chunk_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready) begin
        if (expected_chunks_q.size() == 0) begin
          report_mismatch($sformatf("unexpected chunk %h bytes %0d done %0b",
                                    out_if.out_chunk, out_if.chunk_bytes,
                                    out_if.stream_done));
        end else begin
          want = expected_chunks_q.pop_front();
          if (out_if.out_chunk !== want.chunk)
            report_mismatch($sformatf("out_chunk %h, expected %h",
                                      out_if.out_chunk, want.chunk));
          if (out_if.chunk_bytes !== want.nbytes)
            report_mismatch($sformatf("chunk_bytes %0d, expected %0d",
                                      out_if.chunk_bytes, want.nbytes));
          if (out_if.stream_done !== want.done)
            report_mismatch($sformatf("stream_done %0b, expected %0b",
                                      out_if.stream_done, want.done));
        end
      end
    end
  end

  task automatic test_empty_stream();
    send_item(8'hFF, 1'b0, 1'b0);
    send_end_mark(1'b0, 8'h00);
  endtask

  task automatic test_single_bytes();
    send_byte(8'h00);
    send_end_mark(1'b0, 8'h00);
    send_end_mark(1'b1, 8'hFF);
  endtask

  // A pair opens a run only where a new stretch would begin.
  task automatic test_pairs();
    send_byte(8'h80);
    send_byte(8'h80);
    send_end_mark(1'b0, 8'h00);
    send_byte(8'h01);
    send_byte(8'h7F);
    send_byte(8'h7F);
    send_end_mark(1'b0, 8'h00);
  endtask

  task automatic test_triple_break();
    send_byte(8'h12);
    send_byte(8'h34);
    send_byte(8'hFE);
    send_byte(8'hFE);
    send_byte(8'hFE);
    send_item(8'h55, 1'b0, 1'b0);
    send_end_mark(1'b1, 8'hFE);
  endtask

  // Runs past the run cap and a literal past the store depth, with no idling.
  task automatic test_long_segments();
    logic [7:0] b;
    src_idle_en = 1'b0;
    snk_idle_en = 1'b0;
    b = 8'($urandom);
    repeat ($urandom_range(129, 132)) send_byte(b);
    repeat ($urandom_range(129, 134)) begin
      b = b ^ 8'($urandom_range(1, 255));
      send_byte(b);
    end
    send_end_mark(1'b0, 8'h00);
    src_idle_en = 1'b1;
    snk_idle_en = 1'b1;
  endtask

  function automatic logic [7:0] pick_byte(input bit narrow);
    return narrow ? 8'($urandom_range(0, 3)) : 8'($urandom);
  endfunction

  task automatic test_random_streams(input int unsigned target);
    int unsigned sent;
    int unsigned streams;
    int unsigned len;
    bit narrow;
    logic [7:0] b;
    sent = 0;
    streams = 0;
    while (sent < target) begin
      narrow = ($urandom_range(0, 9) < 3);
      repeat ($urandom_range(1, 6)) begin
        case ($urandom_range(0, 9))
          0, 1, 2: begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(3, 8);
            b = pick_byte(narrow);
            repeat (len) send_byte(b);
            sent += len;
          end
          3, 4, 5: begin
            len = $urandom_range(1, 10);
            b = pick_byte(narrow);
            repeat (len) begin
              b = narrow ? pick_byte(1'b1) : b ^ 8'($urandom_range(1, 255));
              send_byte(b);
            end
            sent += len;
          end
          6: begin
            b = pick_byte(narrow);
            repeat (2) send_byte(b);
            sent += 2;
          end
          7: begin
            len = $urandom_range(1, 6);
            repeat (len) send_byte(8'($urandom));
            sent += len;
          end
          8: begin
            send_byte(pick_byte(narrow));
            b = pick_byte(narrow);
            repeat (3) send_byte(b);
            sent += 4;
          end
          default: begin
            repeat ($urandom_range(1, 3)) send_item(8'($urandom), 1'b0, 1'b0);
          end
        endcase
        // Pauses after each segment of the fourth stream while bytes are still held inside the encoder.
        if (streams == 3 && sent > 0) wait_drained();
      end
      send_end_mark(1'($urandom_range(0, 1)), pick_byte(narrow));
      sent++;
      streams++;
      if (streams % 5 == 0) wait_drained();
    end
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.data_byte = 8'h00;
    in_if.byte_present = 1'b0;
    in_if.end_of_data = 1'b0;
    rst_n = 1'b0;
    err_count = 0;
    cycle_count = 0;
    src_idle_en = 1'b1;
    snk_idle_en = 1'b1;
    reset_encoder_state();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_stream();
    test_single_bytes();
    test_pairs();
    test_triple_break();
    test_long_segments();
    test_random_streams(190);

    in_if.valid <= 1'b0;
    for (int i = 0; i < 20000 && expected_chunks_q.size() != 0; i++) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    while (expected_chunks_q.size() != 0) begin
      report_mismatch($sformatf("missing chunk %h", expected_chunks_q[0].chunk));
      void'(expected_chunks_q.pop_front());
    end
    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/rle_pkg.sv
hw/rtl/rle_if.sv
hw/rtl/rle_ram.sv
hw/rtl/rle_pack.sv
hw/rtl/run_length_byte_encoder.sv
tb/tb_top.sv
